@@ rtl/valve_job_queue_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Valve job queue sequencer assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef VALVE_JOB_QUEUE_SEQUENCER_DEFINES_SVH
`define VALVE_JOB_QUEUE_SEQUENCER_DEFINES_SVH

// clocked assertion, off while reset is high
`define VJQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define VJQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/vjq_pkg.sv @@
// ----------------------------------------------------------------------------
// Valve job queue package
// Field widths, command codes and transfer types shared by the sequencer.
// ----------------------------------------------------------------------------
package vjq_pkg;

   localparam int MODE_W  = 2;
   localparam int ZONE_W  = 8;
   localparam int DUR_W   = 17;
   localparam int TIME_W  = 32;
   localparam int OTIME_W = 27;
   localparam int PEND_W  = 4;
   localparam int PAUSE_W = 16;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd3;

   localparam logic [DUR_W-1:0]   MAX_DURATION_SEC = 17'd86400;
   localparam logic [9:0]         MS_PER_SEC       = 10'd1000;
   localparam logic [PAUSE_W-1:0] PAUSE_RESET      = 16'd1000;
   localparam int                 PEND_MAX         = 15;
   localparam int                 CMD_FIFO_DEPTH   = 2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ZONE_W-1:0] zone;
      logic [DUR_W-1:0]  duration_sec;
      logic [TIME_W-1:0] now_ms;
      logic [ZONE_W-1:0] open_zone_now;
      logic              valve_accepts;
   } cmd_type;

   typedef struct packed {
      logic [ZONE_W-1:0] zone;
      logic [DUR_W-1:0]  duration_sec;
   } entry_type;

   typedef struct packed {
      logic               accepted;
      logic               open_cmd;
      logic [ZONE_W-1:0]  open_zone;
      logic [OTIME_W-1:0] open_time_ms;
      logic               job_done;
      logic [ZONE_W-1:0]  done_zone;
      logic [PEND_W-1:0]  pending;
   } rsp_type;

endpackage

@@ rtl/vjq_front.sv @@
// ----------------------------------------------------------------------------
// Valve job queue front end
// Takes request transfers, saturates the duration and packs the command.
// ----------------------------------------------------------------------------
module vjq_front (
   input  logic                         reset,
   input  logic                         start,
   input  logic [vjq_pkg::MODE_W-1:0]   req_mode,
   input  logic [vjq_pkg::ZONE_W-1:0]   req_zone,
   input  logic [vjq_pkg::DUR_W-1:0]    req_duration_sec,
   input  logic [vjq_pkg::TIME_W-1:0]   req_now_ms,
   input  logic [vjq_pkg::ZONE_W-1:0]   req_open_zone_now,
   input  logic                         req_valve_accepts,
   input  logic                         fifo_full,
   output logic                         busy,
   output logic                         push,
   output vjq_pkg::cmd_type             cmd
);

   always_comb begin
      busy = fifo_full | reset;
      push = start & ~busy;
      cmd.mode          = req_mode;
      cmd.zone          = req_zone;
      cmd.now_ms        = req_now_ms;
      cmd.open_zone_now = req_open_zone_now;
      cmd.valve_accepts = req_valve_accepts;
      if (req_duration_sec > vjq_pkg::MAX_DURATION_SEC) begin
         cmd.duration_sec = vjq_pkg::MAX_DURATION_SEC;
      end else begin
         cmd.duration_sec = req_duration_sec;
      end
   end

endmodule

@@ rtl/vjq_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Valve job queue command FIFO
// Short command queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module vjq_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vjq_pkg::cmd_type push_data,
   input  logic             pop,
   output logic             head_valid,
   output vjq_pkg::cmd_type head_data,
   output logic             full
);

   localparam int DEPTH = vjq_pkg::CMD_FIFO_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vjq_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head_data  = entry_ff[rd_ptr_ff];
      do_push    = push & ~full;
      do_pop     = pop & head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/vjq_back.sv @@
// ----------------------------------------------------------------------------
// Valve job queue sequencer back end
// Job memory, queue pointers and the command sequencer that walks entries.
// ----------------------------------------------------------------------------
module vjq_back #(
   parameter int QUEUE_DEPTH = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [vjq_pkg::PAUSE_W-1:0] csr_wr_data,
   input  logic                        head_valid,
   input  vjq_pkg::cmd_type            head_data,
   output logic                        pop,
   output logic                        rsp_valid,
   output vjq_pkg::rsp_type            rsp
);

   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int PW     = (CNT_W > vjq_pkg::PEND_W) ? CNT_W : vjq_pkg::PEND_W;
   localparam int PROD_W = vjq_pkg::DUR_W + $bits(vjq_pkg::MS_PER_SEC);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_TICK  = 2'd3;

   vjq_pkg::entry_type mem [QUEUE_DEPTH];
   vjq_pkg::entry_type rd_data_ff;
   vjq_pkg::entry_type wr_data;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               we;

   logic [1:0]                  state_ff, state_in;
   vjq_pkg::cmd_type            cmd_ff, cmd_in;
   logic [vjq_pkg::PAUSE_W-1:0] pause_ms_ff;
   logic [CNT_W-1:0]            len_ff, len_in;
   logic [IDX_W-1:0]            cur_ff, cur_in;
   logic                        cur_vld_ff, cur_vld_in;
   logic [vjq_pkg::TIME_W-1:0]  pause_until_ff, pause_until_in;
   logic [QUEUE_DEPTH-1:0]      started_ff, started_in;
   logic [CNT_W-1:0]            ptr_ff, ptr_in;
   logic                        pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]            pipe_idx_ff, pipe_idx_in;
   logic [IDX_W-1:0]            found_ff, found_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   vjq_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         fin, hit, zone_open, entry_open;
   logic                         r_acc, r_open, r_done;
   logic [vjq_pkg::ZONE_W-1:0]   r_ozone, r_dzone;
   logic [vjq_pkg::OTIME_W-1:0]  r_otime;
   logic [CNT_W-1:0]             cur_ext, cur_p1, len_m1;
   logic [PROD_W-1:0]            prod;
   logic [PW-1:0]                pend_w;
   logic [vjq_pkg::TIME_W-1:0]   pause_next;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      len_in         = len_ff;
      cur_in         = cur_ff;
      cur_vld_in     = cur_vld_ff;
      pause_until_in = pause_until_ff;
      started_in     = started_ff;
      ptr_in         = ptr_ff;
      pipe_vld_in    = pipe_vld_ff;
      pipe_idx_in    = pipe_idx_ff;
      found_in       = found_ff;
      pop            = 1'b0;
      rd_addr        = cur_ff;
      we             = 1'b0;
      wr_addr        = len_ff[IDX_W-1:0];
      wr_data.zone         = cmd_ff.zone;
      wr_data.duration_sec = cmd_ff.duration_sec;
      fin     = 1'b0;
      r_acc   = 1'b0;
      r_open  = 1'b0;
      r_ozone = '0;
      r_otime = '0;
      r_done  = 1'b0;
      r_dzone = '0;

      hit        = pipe_vld_ff && (rd_data_ff.zone == cmd_ff.zone);
      zone_open  = (cmd_ff.zone != '0) && (cmd_ff.zone == cmd_ff.open_zone_now);
      entry_open = (rd_data_ff.zone != '0) && (rd_data_ff.zone == cmd_ff.open_zone_now);
      cur_ext    = CNT_W'(cur_ff);
      cur_p1     = cur_ext + CNT_W'(1);
      len_m1     = len_ff - CNT_W'(1);
      prod       = PROD_W'(rd_data_ff.duration_sec) * PROD_W'(vjq_pkg::MS_PER_SEC);
      pause_next = cmd_ff.now_ms + vjq_pkg::TIME_W'(pause_ms_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop         = 1'b1;
               cmd_in      = head_data;
               ptr_in      = '0;
               pipe_vld_in = 1'b0;
               unique case (head_data.mode) inside
                  vjq_pkg::MODE_ENQUEUE, vjq_pkg::MODE_REMOVE: begin
                     state_in = ST_SCAN;
                  end
                  vjq_pkg::MODE_CLEAR: begin
                     fin            = 1'b1;
                     len_in         = '0;
                     cur_vld_in     = 1'b0;
                     cur_in         = '0;
                     pause_until_in = '0;
                  end
                  vjq_pkg::MODE_TICK: begin
                     if (cur_vld_ff && (cur_ext < len_ff) &&
                         (head_data.now_ms >= pause_until_ff)) begin
                        state_in = ST_TICK;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               found_in    = pipe_idx_ff;
               pipe_vld_in = 1'b0;
               if (cmd_ff.mode == vjq_pkg::MODE_REMOVE) begin
                  ptr_in   = CNT_W'(pipe_idx_ff) + CNT_W'(1);
                  state_in = ST_SHIFT;
               end else begin
                  fin      = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (ptr_ff < len_ff) begin
               rd_addr     = ptr_ff[IDX_W-1:0];
               pipe_vld_in = 1'b1;
               pipe_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + CNT_W'(1);
            end else begin
               // zone not listed
               pipe_vld_in = 1'b0;
               fin         = 1'b1;
               state_in    = ST_IDLE;
               if ((cmd_ff.mode == vjq_pkg::MODE_ENQUEUE) &&
                   (len_ff < CNT_W'(QUEUE_DEPTH)) && !zone_open) begin
                  we      = 1'b1;
                  wr_addr = len_ff[IDX_W-1:0];
                  started_in[len_ff[IDX_W-1:0]] = 1'b0;
                  len_in  = len_ff + CNT_W'(1);
                  r_acc   = 1'b1;
                  if (!cur_vld_ff) begin
                     cur_vld_in     = 1'b1;
                     cur_in         = '0;
                     pause_until_in = '0;
                  end
               end
            end
         end
         ST_SHIFT: begin
            if (pipe_vld_ff) begin
               we      = 1'b1;
               wr_addr = pipe_idx_ff;
               wr_data = rd_data_ff;
            end
            if (ptr_ff < len_ff) begin
               rd_addr     = ptr_ff[IDX_W-1:0];
               pipe_vld_in = 1'b1;
               pipe_idx_in = IDX_W'(ptr_ff - CNT_W'(1));
               ptr_in      = ptr_ff + CNT_W'(1);
            end else begin
               pipe_vld_in = 1'b0;
               if (!pipe_vld_ff) begin
                  fin      = 1'b1;
                  r_acc    = 1'b1;
                  state_in = ST_IDLE;
                  for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                     if (IDX_W'(i) >= found_ff) begin
                        started_in[i] = started_ff[i+1];
                     end
                  end
                  len_in = len_m1;
                  if (len_m1 == '0) begin
                     cur_vld_in     = 1'b0;
                     cur_in         = '0;
                     pause_until_in = '0;
                  end else if (cur_vld_ff && (found_ff == cur_ff)) begin
                     if (cur_ext >= len_m1) begin
                        cur_in = IDX_W'(len_m1 - CNT_W'(1));
                     end
                     pause_until_in = pause_next;
                  end else if (cur_vld_ff && (found_ff < cur_ff)) begin
                     cur_in = cur_ff - IDX_W'(1);
                  end
               end
            end
         end
         ST_TICK: begin
            fin      = 1'b1;
            state_in = ST_IDLE;
            if (!entry_open) begin
               if (!started_ff[cur_ff]) begin
                  if ((cmd_ff.open_zone_now == '0) && cmd_ff.valve_accepts) begin
                     r_open  = 1'b1;
                     r_ozone = rd_data_ff.zone;
                     r_otime = vjq_pkg::OTIME_W'(prod);
                     started_in[cur_ff] = 1'b1;
                  end
               end else begin
                  r_done  = 1'b1;
                  r_dzone = rd_data_ff.zone;
                  if (cur_p1 >= len_ff) begin
                     len_in     = '0;
                     cur_vld_in = 1'b0;
                     cur_in     = '0;
                  end else begin
                     cur_in         = cur_ff + IDX_W'(1);
                     pause_until_in = pause_next;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // jobs after the current one, taken from the updated pointers
      if (!cur_vld_in) begin
         pend_w = PW'(len_in);
      end else if (len_in > (CNT_W'(cur_in) + CNT_W'(1))) begin
         pend_w = PW'(len_in - CNT_W'(cur_in) - CNT_W'(1));
      end else begin
         pend_w = '0;
      end
      if (pend_w > PW'(vjq_pkg::PEND_MAX)) begin
         pend_w = PW'(vjq_pkg::PEND_MAX);
      end

      rsp_valid_in = fin;
      rsp_in       = rsp_ff;
      if (fin) begin
         rsp_in.accepted     = r_acc;
         rsp_in.open_cmd     = r_open;
         rsp_in.open_zone    = r_ozone;
         rsp_in.open_time_ms = r_otime;
         rsp_in.job_done     = r_done;
         rsp_in.done_zone    = r_dzone;
         rsp_in.pending      = vjq_pkg::PEND_W'(pend_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pause_ms_ff    <= vjq_pkg::PAUSE_RESET;
         len_ff         <= '0;
         cur_ff         <= '0;
         cur_vld_ff     <= 1'b0;
         pause_until_ff <= '0;
         started_ff     <= '0;
         ptr_ff         <= '0;
         pipe_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         len_ff         <= len_in;
         cur_ff         <= cur_in;
         cur_vld_ff     <= cur_vld_in;
         pause_until_ff <= pause_until_in;
         started_ff     <= started_in;
         ptr_ff         <= ptr_in;
         pipe_vld_ff    <= pipe_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            pause_ms_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pipe_idx_ff <= pipe_idx_in;
      found_ff    <= found_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ rtl/valve_job_queue_sequencer.sv @@
// ----------------------------------------------------------------------------
// Valve job queue sequencer
// Watering job queue with enqueue, remove, clear and tick commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; up to two commands
// wait in a queue while the sequencer works, and busy is high while that
// queue is full. Every command gives one result, shown for one cycle with
// rsp_valid and not held for the receiver. In the sequencer a clear and a
// tick that fails the pointer and pause test finish straight from idle, a
// tick that passes it goes on through the tick state, and an enqueue or a
// remove walks the queued jobs, one entry per cycle on its single read port,
// a remove then shifting the later entries down. The result is registered
// and shows in the cycle after the sequencer finishes.
module valve_job_queue_sequencer #(
   parameter int QUEUE_DEPTH = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [vjq_pkg::MODE_W-1:0]   req_mode,
   input  logic [vjq_pkg::ZONE_W-1:0]   req_zone,
   input  logic [vjq_pkg::DUR_W-1:0]    req_duration_sec,
   input  logic [vjq_pkg::TIME_W-1:0]   req_now_ms,
   input  logic [vjq_pkg::ZONE_W-1:0]   req_open_zone_now,
   input  logic                         req_valve_accepts,
   output logic                         rsp_valid,
   output logic                         rsp_accepted,
   output logic                         rsp_open_cmd,
   output logic [vjq_pkg::ZONE_W-1:0]   rsp_open_zone,
   output logic [vjq_pkg::OTIME_W-1:0]  rsp_open_time_ms,
   output logic                         rsp_job_done,
   output logic [vjq_pkg::ZONE_W-1:0]   rsp_done_zone,
   output logic [vjq_pkg::PEND_W-1:0]   rsp_pending,
   input  logic                         csr_wr_en,
   input  logic [vjq_pkg::PAUSE_W-1:0]  csr_wr_data
);

   vjq_pkg::cmd_type push_cmd, head_cmd;
   vjq_pkg::rsp_type rsp;
   logic             push, pop, head_valid, fifo_full;

   vjq_front u_front (
      .reset             (reset),
      .start             (start),
      .req_mode          (req_mode),
      .req_zone          (req_zone),
      .req_duration_sec  (req_duration_sec),
      .req_now_ms        (req_now_ms),
      .req_open_zone_now (req_open_zone_now),
      .req_valve_accepts (req_valve_accepts),
      .fifo_full         (fifo_full),
      .busy              (busy),
      .push              (push),
      .cmd               (push_cmd)
   );

   vjq_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_cmd),
      .full       (fifo_full)
   );

   vjq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_valid  (head_valid),
      .head_data   (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_accepted     = rsp.accepted;
   assign rsp_open_cmd     = rsp.open_cmd;
   assign rsp_open_zone    = rsp.open_zone;
   assign rsp_open_time_ms = rsp.open_time_ms;
   assign rsp_job_done     = rsp.job_done;
   assign rsp_done_zone    = rsp.done_zone;
   assign rsp_pending      = rsp.pending;

endmodule

@@ rtl/vjq_port_checker.sv @@
// ----------------------------------------------------------------------------
// Valve job queue port checker
// Port level checks of transfers and results, bound to the top level.
// ----------------------------------------------------------------------------
`include "valve_job_queue_sequencer_defines.svh"

module vjq_port_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic                        rsp_open_cmd,
   input logic [vjq_pkg::OTIME_W-1:0] rsp_open_time_ms
);

   logic [2:0] outstanding_ff, outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff + 3'((start && !busy) ? 1 : 0) -
                       3'(rsp_valid ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `VJQ_ASSERT(a_rsp_has_cmd, clock, reset, rsp_valid |-> outstanding_ff != 3'd0, "result without a pending transfer")
   `VJQ_ASSERT(a_busy_has_cmds, clock, reset, busy |-> outstanding_ff >= 3'd2, "busy with fewer than two pending transfers")
   `VJQ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result right after reset")
   `VJQ_ASSERT(a_open_time_range, clock, reset, (rsp_valid && rsp_open_cmd) |-> rsp_open_time_ms <= 27'd86400000, "open time beyond one day")

endmodule

bind valve_job_queue_sequencer vjq_port_checker u_vjq_port_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_open_cmd     (rsp_open_cmd),
   .rsp_open_time_ms (rsp_open_time_ms)
);
